@@ rtl/core/mtc_pkg.sv @@
// Shared types and constants for the magnetometer trim compensation block.
`default_nettype none

package mtc_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_XY_TRIMS  = 3'd0;
  localparam logic [2:0] CFG_TRIM_Z1   = 3'd1;
  localparam logic [2:0] CFG_TRIM_Z2   = 3'd2;
  localparam logic [2:0] CFG_TRIM_Z3   = 3'd3;
  localparam logic [2:0] CFG_TRIM_Z4   = 3'd4;
  localparam logic [2:0] CFG_TRIM_XYZ1 = 3'd5;

  // Compensation constants
  localparam logic [15:0]        T_OFFSET  = 16'h4000;
  localparam logic signed [33:0] XY_BASE   = 34'sh0010_0000;
  localparam logic signed [9:0]  XY_C2_OFS = 10'sh0A0;
  localparam logic signed [63:0] Z_ROUND   = 64'sd32768;

  // Serial divider: one quotient bit per cycle over a 32-bit dividend
  localparam int unsigned DIV_BITS = 32;
  localparam logic [4:0]  DIV_LAST = 5'(DIV_BITS - 1);

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVXY,
    ST_MUL,
    ST_DIVZ,
    ST_DONE
  } mtc_state_e;

  // Shared multiplier steps
  typedef enum logic [3:0] {
    STEP_TT,  // t*t
    STEP_A1,  // xy2 * (t*t >> 7)
    STEP_A2,  // + t * xy1 * 128
    STEP_BX,  // x scale term
    STEP_PX,  // x result
    STEP_BY,  // y scale term
    STEP_PY,  // y result
    STEP_ZN,  // z numerator
    STEP_ZD,  // z divisor
    STEP_ZL   // check divisor, start z division
  } mtc_step_e;

endpackage

`default_nettype wire

@@ rtl/core/magnetometer_trim_compensation.sv @@
// Top level: magnetometer trim compensation with shared multiplier and divider.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------
//   in      | sink      | in_valid_i / in_stall_o | x/y/z_word_i, rhall_word_i
//   out     | source    | out_valid_o/out_stall_i | field_x/y/z_o, fresh_o, divide_error_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A ready sample is accepted, runs the restoring divider for the temperature term,
// the 10 shared-multiplier steps and the divider for z, and then finishes. With a
// zero x/y divisor the first division and the x/y steps are skipped. A sample
// without data ready goes straight to the finish.
// Reset is asynchronous, active low, and clears trims and held values.
// The input stalls while a sample is in work; a result waiting in the output
// register does not stall the input, only the finish of the next sample.
`default_nettype none

module magnetometer_trim_compensation
  import mtc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [15:0]        x_word_i,
  input  wire logic [15:0]        y_word_i,
  input  wire logic [15:0]        z_word_i,
  input  wire logic [15:0]        rhall_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      field_x_o,
  output logic signed [15:0]      field_y_o,
  output logic signed [15:0]      field_z_o,
  output logic                    fresh_o,
  output logic                    divide_error_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [47:0]        cfg_data_i
);

  // Configuration registers
  logic [47:0] xy_trims_q;
  logic [15:0] trim_z1_q, trim_z2_q, trim_z3_q, trim_z4_q, trim_xyz1_q;

  // Control state
  mtc_state_e state_q, state_d;
  mtc_step_e  step_q;
  logic [4:0] cnt_q;
  logic       out_valid_q;
  logic       err_q;
  logic       fresh_q;

  // Held results
  logic [15:0] held_x_q, held_y_q, held_z_q;

  // Working registers
  logic signed [12:0] mx_q, my_q;
  logic signed [14:0] mz_q;
  logic [13:0]        r_q;
  logic signed [15:0] t_q;
  logic signed [31:0] tt_q;
  logic signed [33:0] a_q;
  logic signed [31:0] bs_q;
  logic signed [31:0] num_q;
  logic signed [17:0] den_q;

  // Divider registers
  logic [31:0] div_quo_q;
  logic [16:0] div_rem_q;
  logic [16:0] div_dvs_q;
  logic        div_neg_q;

  // Output registers
  logic [15:0] out_x_q, out_y_q, out_z_q;
  logic        out_fresh_q, out_err_q;

  // Control strobes
  logic accept, div_run, div_last, mul_run, out_free, out_load;

  // Trim fields
  logic signed [7:0] x1, y1, x2, y2, xy2;
  logic [7:0]        xy1;
  assign x1  = xy_trims_q[7:0];
  assign y1  = xy_trims_q[15:8];
  assign x2  = xy_trims_q[23:16];
  assign y2  = xy_trims_q[31:24];
  assign xy1 = xy_trims_q[39:32];
  assign xy2 = xy_trims_q[47:40];

  // Input field extraction and x/y divisor choice
  logic [13:0] r_in;
  logic [15:0] dxy;
  assign r_in = rhall_word_i[15:2];
  assign dxy  = (r_in != 14'd0) ? {2'b00, r_in} : trim_xyz1_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!rhall_word_i[0]) state_d = ST_DONE;
          else if (dxy != 16'd0) state_d = ST_DIVXY;
          else state_d = ST_MUL;
        end
      end
      ST_DIVXY: begin
        if (cnt_q == DIV_LAST) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (step_q == STEP_ZL) state_d = (den_q == 18'sd0) ? ST_DONE : ST_DIVZ;
      end
      ST_DIVZ: begin
        if (cnt_q == DIV_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    div_run    = (state_q == ST_DIVXY) || (state_q == ST_DIVZ);
    div_last   = div_run && (cnt_q == DIV_LAST);
    mul_run    = (state_q == ST_MUL);
    out_free   = !out_valid_q || !out_stall_i;
    out_load   = (state_q == ST_DONE) && out_free;
  end

  // Shared multiplier operand select
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [9:0]  c2x, c2y;
  logic signed [17:0] zdiff;
  assign c2x   = {{2{x2[7]}}, x2} + XY_C2_OFS;
  assign c2y   = {{2{y2[7]}}, y2} + XY_C2_OFS;
  assign zdiff = $signed({4'b0000, r_q}) - $signed({{2{trim_xyz1_q[15]}}, trim_xyz1_q});

  logic signed [33:0] a_scaled;
  assign a_scaled = (a_q >>> 9) + XY_BASE;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      STEP_TT: begin
        mul_a = {{16{t_q[15]}}, t_q};
        mul_b = {{16{t_q[15]}}, t_q};
      end
      STEP_A1: begin
        mul_a = {{24{xy2[7]}}, xy2};
        mul_b = tt_q;
      end
      STEP_A2: begin
        mul_a = {{16{t_q[15]}}, t_q};
        mul_b = {17'b0, xy1, 7'b0};
      end
      STEP_BX: begin
        mul_a = a_scaled[31:0];
        mul_b = {{22{c2x[9]}}, c2x};
      end
      STEP_PX: begin
        mul_a = {{19{mx_q[12]}}, mx_q};
        mul_b = bs_q;
      end
      STEP_BY: begin
        mul_a = a_scaled[31:0];
        mul_b = {{22{c2y[9]}}, c2y};
      end
      STEP_PY: begin
        mul_a = {{19{my_q[12]}}, my_q};
        mul_b = bs_q;
      end
      STEP_ZN: begin
        mul_a = {{16{trim_z3_q[15]}}, trim_z3_q};
        mul_b = {{14{zdiff[17]}}, zdiff};
      end
      STEP_ZD: begin
        mul_a = {16'b0, trim_z1_q};
        mul_b = {17'b0, r_q, 1'b0};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // z numerator and divisor from the product
  logic signed [16:0] mzdiff;
  logic signed [32:0] num_w;
  logic signed [63:0] dsum;
  logic signed [17:0] den_w;
  assign mzdiff = $signed({{2{mz_q[14]}}, mz_q}) - $signed({trim_z4_q[15], trim_z4_q});
  assign num_w  = $signed({mzdiff[16], mzdiff, 15'b0}) - $signed({mul_p[33], mul_p[33:2]});
  assign dsum   = mul_p + Z_ROUND;
  assign den_w  = $signed({{2{trim_z2_q[15]}}, trim_z2_q}) + $signed({2'b00, dsum[31:16]});

  // Divider step: one restoring subtract per cycle
  logic [17:0] rem_sh, rem_sub;
  logic        div_ge;
  logic [16:0] rem_next;
  logic [31:0] quo_next;
  logic [15:0] z_quo;
  assign rem_sh   = {div_rem_q, div_quo_q[31]};
  assign rem_sub  = rem_sh - {1'b0, div_dvs_q};
  assign div_ge   = (rem_sh >= {1'b0, div_dvs_q});
  assign rem_next = div_ge ? rem_sub[16:0] : rem_sh[16:0];
  assign quo_next = {div_quo_q[30:0], div_ge};
  assign z_quo    = div_neg_q ? (16'd0 - quo_next[15:0]) : quo_next[15:0];

  // z division operands
  logic [31:0] num_mag;
  logic [17:0] den_mag;
  assign num_mag = num_q[31] ? (32'd0 - num_q) : num_q;
  assign den_mag = den_q[17] ? (18'd0 - den_q) : den_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xy_trims_q  <= '0;
      trim_z1_q   <= '0;
      trim_z2_q   <= '0;
      trim_z3_q   <= '0;
      trim_z4_q   <= '0;
      trim_xyz1_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_XY_TRIMS:  xy_trims_q  <= cfg_data_i;
        CFG_TRIM_Z1:   trim_z1_q   <= cfg_data_i[15:0];
        CFG_TRIM_Z2:   trim_z2_q   <= cfg_data_i[15:0];
        CFG_TRIM_Z3:   trim_z3_q   <= cfg_data_i[15:0];
        CFG_TRIM_Z4:   trim_z4_q   <= cfg_data_i[15:0];
        CFG_TRIM_XYZ1: trim_xyz1_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Control registers, held results and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_TT;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_z_q    <= '0;
    end else begin
      state_q <= state_d;

      // Start a transaction: pick the first step
      if (accept) begin
        fresh_q <= rhall_word_i[0];
        err_q   <= rhall_word_i[0] && (dxy == 16'd0);
        step_q  <= (dxy != 16'd0) ? STEP_TT : STEP_ZN;
        cnt_q   <= '0;
      end

      // Advance the divider count
      if (div_run) begin
        cnt_q <= div_last ? 5'd0 : cnt_q + 5'd1;
      end

      // Advance the multiplier steps and store results
      if (mul_run) begin
        if (step_q != STEP_ZL) step_q <= mtc_step_e'(step_q + 4'd1);
        if (step_q == STEP_PX) held_x_q <= mul_p[28:13] + {{5{x1[7]}}, x1, 3'b000};
        if (step_q == STEP_PY) held_y_q <= mul_p[28:13] + {{5{y1[7]}}, y1, 3'b000};
        if ((step_q == STEP_ZL) && (den_q == 18'sd0)) err_q <= 1'b1;
      end

      // Store z at the end of its division
      if (div_last && (state_q == ST_DIVZ)) held_z_q <= z_quo;

      // Hand the result to the output register
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Working datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mx_q      <= x_word_i[15:3];
      my_q      <= y_word_i[15:3];
      mz_q      <= z_word_i[15:1];
      r_q       <= r_in;
      div_quo_q <= {2'b00, trim_xyz1_q, 14'b0};
      div_rem_q <= '0;
      div_dvs_q <= {1'b0, dxy};
      div_neg_q <= 1'b0;
    end

    if (div_run) begin
      div_quo_q <= quo_next;
      div_rem_q <= rem_next;
      if (div_last && (state_q == ST_DIVXY)) t_q <= quo_next[15:0] - T_OFFSET;
    end

    if (mul_run) begin
      case (step_q)
        STEP_TT: tt_q  <= mul_p[38:7];
        STEP_A1: a_q   <= mul_p[33:0];
        STEP_A2: a_q   <= a_q + mul_p[33:0];
        STEP_BX: bs_q  <= mul_p[43:12];
        STEP_BY: bs_q  <= mul_p[43:12];
        STEP_ZN: num_q <= num_w[31:0];
        STEP_ZD: den_q <= den_w;
        STEP_ZL: begin
          div_quo_q <= num_mag;
          div_rem_q <= '0;
          div_dvs_q <= den_mag[16:0];
          div_neg_q <= num_q[31] ^ den_q[17];
        end
        default: ;
      endcase
    end

    if (out_load) begin
      out_x_q     <= held_x_q;
      out_y_q     <= held_y_q;
      out_z_q     <= held_z_q;
      out_fresh_q <= fresh_q;
      out_err_q   <= err_q;
    end
  end

  // Drive outputs
  assign out_valid_o    = out_valid_q;
  assign field_x_o      = out_x_q;
  assign field_y_o      = out_y_q;
  assign field_z_o      = out_z_q;
  assign fresh_o        = out_fresh_q;
  assign divide_error_o = out_err_q;

`ifndef SYNTHESIS
  // A sample without data ready goes straight to the finish
  a_not_ready_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !rhall_word_i[0] |=> state_q == ST_DONE)
    else $error("not-ready sample did not go to finish");

  // The output register takes the held values
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && field_x_o == $past(held_x_q)
                 && field_z_o == $past(held_z_q))
    else $error("output register missed held values");

  // The partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_run |-> div_rem_q < div_dvs_q)
    else $error("divider remainder out of range");

  // An error is reported only with ready data
  a_err_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fresh_o |-> !divide_error_o)
    else $error("divide error without ready data");
`endif

endmodule

`default_nettype wire
